// ----- sv/hth_pkg.sv -----
// package for the hit time difference histogram: defaults, widths and state codes
`timescale 1ns / 1ps

package hth_pkg;

    localparam int CHANNELS_DEF     = 12;
    localparam int WINDOW_BINS_DEF  = 70;
    localparam int HIT_MASK_BITS    = 12;
    localparam int WINDOW_LOW_BITS  = 10;
    localparam int TIME_BITS        = 32;
    localparam int COUNT_BITS       = 32;
    localparam int READ_CH_BITS     = 4;
    localparam int READ_BIN_BITS    = 7;

    localparam logic signed [WINDOW_LOW_BITS-1:0] WINDOW_LOW_RESET = -10'sd20;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLEAR = 4'b0010,
        S_HIT   = 4'b0100,
        S_READ  = 4'b1000
    } t_state;

endpackage

// ----- sv/hit_time_difference_histogram.sv -----
// top level of the hit time difference histogram
`timescale 1ns / 1ps
// hit item: busy from acceptance until every channel is issued and the pipeline drains,
// one bin read-modify-write per issue cycle through the single histogram ram
// read item: ram read issued at acceptance, S_READ registers the count and result strobe, next read taken in idle
// reset: synchronous, then a clearing pass over all CHANNELS*(WINDOW_BINS+2) bins
// (864 by default) during which busy is high; results cannot be stalled
module hit_time_difference_histogram
#(
    parameter int CHANNELS    = hth_pkg::CHANNELS_DEF,
    parameter int WINDOW_BINS = hth_pkg::WINDOW_BINS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic                                       i_func,
    input  logic [hth_pkg::HIT_MASK_BITS-1:0]          i_hit_mask,
    input  logic                                       i_ref_hit,
    input  logic [hth_pkg::TIME_BITS-1:0]              i_tdc_count,
    input  logic [hth_pkg::TIME_BITS-1:0]              i_sync_count,
    input  logic [hth_pkg::READ_CH_BITS-1:0]           i_read_channel,
    input  logic [hth_pkg::READ_BIN_BITS-1:0]          i_read_bin,
    input  logic                                       i_cfg_we,
    input  logic signed [hth_pkg::WINDOW_LOW_BITS-1:0] i_cfg_wdata,
    output logic                                       o_valid,
    output logic [hth_pkg::COUNT_BITS-1:0]             o_bin_count
);

    import hth_pkg::*;

    localparam int ROW_BINS = WINDOW_BINS + 2;
    localparam int STORE    = CHANNELS * ROW_BINS;
    localparam int AW       = $clog2(STORE);
    localparam int BW       = $clog2(ROW_BINS);
    localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_state r_state;
    logic signed [WINDOW_LOW_BITS-1:0] r_window_low;
    logic [TIME_BITS-1:0] r_last [CHANNELS];
    logic [TIME_BITS-1:0] r_ref_last;
    logic [TIME_BITS-1:0] r_now;
    logic [CHANNELS-1:0]  r_mask;
    logic                 r_ref;
    logic [CW-1:0]        r_ch;
    logic                 r_phase;
    logic [AW-1:0]        r_row_base;
    logic [AW-1:0]        r_clr_addr;

    logic                 r_a_valid;
    logic [TIME_BITS-1:0] r_a_diff;
    logic [AW-1:0]        r_a_base;
    logic                 r_b_valid;
    logic [AW-1:0]        r_b_addr;
    logic                 r_pw_valid;
    logic [AW-1:0]        r_pw_addr;
    logic [COUNT_BITS-1:0] r_pw_data;

    logic                 r_rd_ok;
    logic                 r_out_valid;
    logic [COUNT_BITS-1:0] r_bin_count;

    logic                 accept;
    logic                 last_issue;
    logic                 n_a_valid;
    logic [TIME_BITS-1:0] n_a_diff;
    logic signed [TIME_BITS+1:0] off;
    logic [BW-1:0]        n_bin;
    logic [AW-1:0]        n_b_addr;
    logic [31:0]          rd_lin;
    logic                 rd_ok;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] n_count;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    assign busy       = (r_state != S_IDLE) || r_a_valid || r_b_valid;
    assign accept     = start && !busy;
    assign last_issue = (r_state == S_HIT) && r_phase && (r_ch == CW'(CHANNELS - 1));

    // issue: one channel per cycle, mask fills then reference fills
    always_comb begin
        n_a_valid = 1'b0;
        n_a_diff  = r_now - r_ref_last;
        if (r_state == S_HIT) begin
            if (!r_phase) begin
                n_a_valid = r_mask[r_ch];
            end else begin
                n_a_valid = r_ref;
                n_a_diff  = r_last[r_ch] - r_now;
            end
        end
    end

    // bin select
    always_comb begin
        off = (TIME_BITS+2)'(signed'(r_a_diff)) - (TIME_BITS+2)'(r_window_low);
        if (off[TIME_BITS+1]) begin
            n_bin = '0;
        end else if (off >= (TIME_BITS+2)'(WINDOW_BINS)) begin
            n_bin = BW'(WINDOW_BINS + 1);
        end else begin
            n_bin = BW'(off) + BW'(1);
        end
        n_b_addr = r_a_base + AW'(n_bin);
    end

    assign rd_lin = 32'(i_read_channel) * 32'(ROW_BINS) + 32'(i_read_bin);
    assign rd_ok  = (32'(i_read_channel) < 32'(CHANNELS)) && (32'(i_read_bin) < 32'(ROW_BINS));

    // modify with forwarding of the write from the cycle before
    assign cur     = (r_pw_valid && r_pw_addr == r_b_addr) ? r_pw_data : ram_rdata;
    assign n_count = (cur == '1) ? cur : cur + COUNT_BITS'(1);

    always_comb begin
        ram_we    = r_b_valid;
        ram_waddr = r_b_addr;
        ram_wdata = n_count;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end
        ram_re    = r_a_valid || (accept && i_func);
        ram_raddr = r_a_valid ? n_b_addr : rd_lin[AW-1:0];
    end

    hth_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (STORE)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_window_low <= WINDOW_LOW_RESET;
            r_ref_last   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_last[c] <= '0;
            end
            r_clr_addr   <= '0;
            r_ch         <= '0;
            r_phase      <= 1'b0;
            r_row_base   <= '0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_pw_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window_low <= i_cfg_wdata;
            end
            r_a_valid   <= n_a_valid;
            r_b_valid   <= r_a_valid;
            r_pw_valid  <= r_b_valid;
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(STORE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state    <= i_func ? S_READ : S_HIT;
                        r_ch       <= '0;
                        r_phase    <= 1'b0;
                        r_row_base <= '0;
                    end
                end
                S_HIT: begin
                    if (r_ch == CW'(CHANNELS - 1)) begin
                        r_ch       <= '0;
                        r_row_base <= '0;
                        r_phase    <= 1'b1;
                    end else begin
                        r_ch       <= r_ch + CW'(1);
                        r_row_base <= r_row_base + AW'(ROW_BINS);
                    end
                    if (last_issue) begin
                        r_state <= S_IDLE;
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (r_mask[c]) begin
                                r_last[c] <= r_now;
                            end
                        end
                        if (r_ref) begin
                            r_ref_last <= r_now;
                        end
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now   <= i_tdc_count + i_sync_count;
            r_mask  <= CHANNELS'(i_hit_mask);
            r_ref   <= i_ref_hit;
            r_rd_ok <= rd_ok;
        end
        r_a_diff  <= n_a_diff;
        r_a_base  <= r_row_base;
        r_b_addr  <= n_b_addr;
        r_pw_addr <= r_b_addr;
        r_pw_data <= n_count;
        if (r_state == S_READ) begin
            r_bin_count <= r_rd_ok ? ram_rdata : '0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_bin_count = r_bin_count;

    a_strobe_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_READ))
        else $error("result strobe without a read");

    a_no_update_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_b_valid)
        else $error("bin update during clearing pass");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (32'(r_b_addr) < 32'(STORE)))
        else $error("bin address beyond store");

endmodule

// ----- sv/hth_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module hth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 864
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
